@@ hw/rtl/ipv6atp_pkg.sv @@
package ipv6atp_pkg;

  localparam int unsigned NumGroups = 8;
  localparam int unsigned WordWidth = 16;

  localparam logic [7:0] ChOpenBracket  = 8'h5B;
  localparam logic [7:0] ChCloseBracket = 8'h5D;
  localparam logic [7:0] ChPipe         = 8'h7C;
  localparam logic [7:0] ChColon        = 8'h3A;
  localparam logic [7:0] ChDot          = 8'h2E;
  localparam logic [7:0] ChDigit0       = 8'h30;
  localparam logic [7:0] ChDigit9       = 8'h39;
  localparam logic [7:0] ChUpperA       = 8'h41;
  localparam logic [7:0] ChUpperF       = 8'h46;
  localparam logic [7:0] ChLowerA       = 8'h61;
  localparam logic [7:0] ChLowerF       = 8'h66;

  localparam logic [3:0] LetterOffset = 4'd9;
  localparam logic [3:0] GroupsFull   = 4'd8;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] word0;
    logic [15:0] word1;
    logic [15:0] word2;
    logic [15:0] word3;
    logic [15:0] word4;
    logic [15:0] word5;
    logic [15:0] word6;
    logic [15:0] word7;
    logic [15:0] port_number;
    logic        ok;
  } out_item_t;

endpackage

@@ hw/rtl/ipv6_address_text_parser.sv @@
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   in_data_i   (ch, last)
// out      output     out_valid_o / out_stall_i out_data_o  (word0..word7, port_number, ok)
//
// One character per cycle unless the input stalls: a character is registered, then parsed in one pass
// into the running state; a last character also forms the result that cycle.
// The result is registered in the output register, or in the skid entry when that register is held.
// Reset clears all parse state; the group stores hold no reset value.
// A two-entry output (register plus skid) absorbs stalls; input stalls only
// when a last character waits while both output entries are full.
module ipv6_address_text_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  ipv6atp_pkg::in_item_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output ipv6atp_pkg::out_item_t out_data_o
);

  logic                  item_valid_q, item_valid_d;
  ipv6atp_pkg::in_item_t item_q;
  logic                  in_accept, advance;

  logic [3:0]        gc_q, gc_d;
  logic [3:0]        zrp_q, zrp_d;
  logic [15:0]       hex_q, hex_d;
  logic [15:0]       dec_q, dec_d;
  logic [7:0]        half_q, half_d;
  logic              dotted_q, dotted_d;
  logic              await_q, await_d;
  logic              brk_q, brk_d;
  logic              cla_q, cla_d;
  logic              stop_q, stop_d;
  logic              fail_q, fail_d;
  logic [7:0][15:0]  hd_q, hd_d;
  logic [7:0][15:0]  sh_q, sh_d;

  logic [7:0]        c;
  logic [7:0]        psep;
  logic              take;
  logic [3:0]        hv;
  logic [15:0]       grp;
  logic [15:0]       port;
  logic [3:0]        zpos;
  logic [3:0]        span;
  logic [7:0][15:0]  words;

  ipv6atp_pkg::out_item_t res;
  logic                   res_valid;
  logic                   out_valid_q, skid_valid_q;
  ipv6atp_pkg::out_item_t out_q, skid_q;
  logic                   drain;

  assign advance    = item_valid_q && (!item_q.last || !skid_valid_q);
  assign in_stall_o = item_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign res_valid  = advance && item_q.last;
  assign drain      = out_valid_q && !out_stall_i;

  always_comb begin
    item_valid_d = item_valid_q;
    if (in_accept) begin
      item_valid_d = 1'b1;
    end else if (advance) begin
      item_valid_d = 1'b0;
    end
  end

  always_comb begin
    gc_d     = gc_q;
    zrp_d    = zrp_q;
    hex_d    = hex_q;
    dec_d    = dec_q;
    half_d   = half_q;
    dotted_d = dotted_q;
    await_d  = await_q;
    brk_d    = brk_q;
    cla_d    = cla_q;
    stop_d   = stop_q;
    fail_d   = fail_q;
    hd_d     = hd_q;
    sh_d     = sh_q;
    c        = item_q.ch;
    psep     = brk_q ? ipv6atp_pkg::ChColon : ipv6atp_pkg::ChPipe;
    take     = 1'b1;
    hv       = 4'd0;
    grp      = 16'd0;
    port     = 16'd0;
    words    = '0;

    if (!fail_q && !stop_q) begin
      if (cla_q) begin
        cla_d = 1'b0;
        if (c == ipv6atp_pkg::ChColon) begin
          zrp_d = gc_q;
          take  = 1'b0;
        end
      end
      if (take) begin
        if (c == ipv6atp_pkg::ChOpenBracket) begin
          take = 1'b0;
        end else if (c == ipv6atp_pkg::ChCloseBracket) begin
          brk_d = 1'b1;
        end else if (c == psep || c == ipv6atp_pkg::ChColon || c == ipv6atp_pkg::ChDot) begin
          if (await_q) begin
            stop_d = 1'b1;
          end else if (gc_q[3]) begin
            fail_d = 1'b1;
          end else begin
            if (dotted_q || c != ipv6atp_pkg::ChDot) begin
              grp               = dotted_q ? {half_q, 8'd0} + dec_q : hex_q;
              hd_d[gc_d[2:0]]   = grp;
              sh_d              = {grp, sh_d[7:1]};
              gc_d              = gc_d + 4'd1;
              dotted_d          = 1'b0;
            end else begin
              half_d   = dec_q[7:0];
              dotted_d = 1'b1;
            end
            hex_d = 16'd0;
            dec_d = 16'd0;
            if (c == psep) begin
              await_d = 1'b1;
            end else begin
              cla_d = 1'b1;
            end
          end
        end else if (c inside {[ipv6atp_pkg::ChDigit0 : ipv6atp_pkg::ChDigit9]}) begin
          hv    = c[3:0];
          hex_d = {hex_q[11:0], hv};
          dec_d = {dec_q[12:0], 3'd0} + {dec_q[14:0], 1'b0} + {12'd0, hv};
        end else if (c inside {[ipv6atp_pkg::ChUpperA : ipv6atp_pkg::ChUpperF],
                               [ipv6atp_pkg::ChLowerA : ipv6atp_pkg::ChLowerF]}) begin
          hv    = c[3:0] + ipv6atp_pkg::LetterOffset;
          hex_d = {hex_q[11:0], hv};
          if (dotted_q) begin
            fail_d = 1'b1;
          end
        end else begin
          fail_d = 1'b1;
        end
      end
    end

    if (item_q.last && !fail_d) begin
      if (await_d) begin
        port = dec_d;
      end else if (gc_d[3]) begin
        fail_d = 1'b1;
      end else begin
        grp             = dotted_d ? {half_d, 8'd0} + dec_d : hex_d;
        hd_d[gc_d[2:0]] = grp;
        sh_d            = {grp, sh_d[7:1]};
        gc_d            = gc_d + 4'd1;
      end
    end

    zpos = (zrp_d > gc_d) ? gc_d : zrp_d;
    span = gc_d - zpos;
    for (int i = 0; i < ipv6atp_pkg::NumGroups; i++) begin
      if (4'(i) < zpos) begin
        words[i] = hd_d[i];
      end else if (5'(i) + {1'b0, span} >= 5'd8) begin
        words[i] = sh_d[i];
      end else begin
        words[i] = 16'd0;
      end
    end
    if (fail_d) begin
      words = '0;
      port  = 16'd0;
    end
  end

  always_comb begin
    res.word0       = words[0];
    res.word1       = words[1];
    res.word2       = words[2];
    res.word3       = words[3];
    res.word4       = words[4];
    res.word5       = words[5];
    res.word6       = words[6];
    res.word7       = words[7];
    res.port_number = port;
    res.ok          = !fail_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      gc_q         <= 4'd0;
      zrp_q        <= 4'd0;
      hex_q        <= 16'd0;
      dec_q        <= 16'd0;
      half_q       <= 8'd0;
      dotted_q     <= 1'b0;
      await_q      <= 1'b0;
      brk_q        <= 1'b0;
      cla_q        <= 1'b0;
      stop_q       <= 1'b0;
      fail_q       <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      if (advance) begin
        if (item_q.last) begin
          gc_q     <= 4'd0;
          zrp_q    <= 4'd0;
          hex_q    <= 16'd0;
          dec_q    <= 16'd0;
          half_q   <= 8'd0;
          dotted_q <= 1'b0;
          await_q  <= 1'b0;
          brk_q    <= 1'b0;
          cla_q    <= 1'b0;
          stop_q   <= 1'b0;
          fail_q   <= 1'b0;
        end else begin
          gc_q     <= gc_d;
          zrp_q    <= zrp_d;
          hex_q    <= hex_d;
          dec_q    <= dec_d;
          half_q   <= half_d;
          dotted_q <= dotted_d;
          await_q  <= await_d;
          brk_q    <= brk_d;
          cla_q    <= cla_d;
          stop_q   <= stop_d;
          fail_q   <= fail_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
    if (advance) begin
      hd_q <= hd_d;
      sh_q <= sh_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (drain) begin
          skid_valid_q <= 1'b0;
        end
      end else if (res_valid) begin
        if (out_valid_q && !drain) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (drain) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (drain) begin
        out_q <= skid_q;
      end
    end else if (res_valid) begin
      if (out_valid_q && !drain) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty output register");

  a_no_result_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !res_valid)
    else $error("result formed while both output entries are full");

  a_group_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gc_q <= ipv6atp_pkg::GroupsFull)
    else $error("group count beyond eight");

  a_zero_run_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zrp_q <= gc_q)
    else $error("zero run position past stored groups");

  a_dotted_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dotted_q |-> !gc_q[3])
    else $error("dotted half open with all groups stored");

endmodule

@@ tb/tb_ipv6_address_text_parser.sv @@
`timescale 1ns / 100ps

module tb_ipv6_address_text_parser;

  localparam int RandomChars  = 1750;
  localparam int IdleLimit    = 2000;
  localparam int DrainCycles  = 20;
  localparam int DecimalBase  = 10;
  localparam int HexLetterVal = 10;

  class address_scoreboard;
    logic [15:0] groups[ipv6atp_pkg::NumGroups];
    int unsigned n_groups;
    int unsigned zero_pos;
    logic [15:0] hex_acc;
    logic [15:0] dec_acc;
    bit          dotted;
    bit          want_port;
    bit          closed;
    bit          colon_pending;
    bit          stopped;
    bit          failed;
    ipv6atp_pkg::out_item_t expected_q[$];
    int          errors;
    int          results;
    int          live_chars;

    function new();
      errors     = 0;
      results    = 0;
      live_chars = 0;
      clear();
    endfunction

    function void clear();
      foreach (groups[i]) groups[i] = '0;
      n_groups      = 0;
      zero_pos      = 0;
      hex_acc       = '0;
      dec_acc       = '0;
      dotted        = 1'b0;
      want_port     = 1'b0;
      closed        = 1'b0;
      colon_pending = 1'b0;
      stopped       = 1'b0;
      failed        = 1'b0;
    endfunction

    function void close_separator(logic [7:0] c, logic [7:0] psep);
      if (want_port) begin
        stopped = 1'b1;
        return;
      end
      if (n_groups >= ipv6atp_pkg::NumGroups) begin
        failed = 1'b1;
        return;
      end
      if (dotted) begin
        groups[n_groups] = (groups[n_groups] << 8) + dec_acc;
        n_groups++;
        dotted = 1'b0;
      end else if (c == ipv6atp_pkg::ChDot) begin
        groups[n_groups] = dec_acc;
        dotted = 1'b1;
      end else begin
        groups[n_groups] = hex_acc;
        n_groups++;
      end
      hex_acc = '0;
      dec_acc = '0;
      if (c == psep) want_port = 1'b1;
      else colon_pending = 1'b1;
    endfunction

    function void parse_char(logic [7:0] c);
      logic [7:0] psep;
      logic [7:0] hv;
      bit         is_digit;
      psep = closed ? ipv6atp_pkg::ChColon : ipv6atp_pkg::ChPipe;
      if (colon_pending) begin
        colon_pending = 1'b0;
        if (c == ipv6atp_pkg::ChColon) begin
          zero_pos = n_groups;
          return;
        end
      end
      if (c == ipv6atp_pkg::ChOpenBracket) return;
      if (c == ipv6atp_pkg::ChCloseBracket) begin
        closed = 1'b1;
        return;
      end
      if (c == psep || c == ipv6atp_pkg::ChColon || c == ipv6atp_pkg::ChDot) begin
        close_separator(c, psep);
        return;
      end
      is_digit = (c >= ipv6atp_pkg::ChDigit0 && c <= ipv6atp_pkg::ChDigit9);
      if (is_digit) hv = c - ipv6atp_pkg::ChDigit0;
      else if (c >= ipv6atp_pkg::ChUpperA && c <= ipv6atp_pkg::ChUpperF)
        hv = 8'(c - ipv6atp_pkg::ChUpperA + HexLetterVal);
      else if (c >= ipv6atp_pkg::ChLowerA && c <= ipv6atp_pkg::ChLowerF)
        hv = 8'(c - ipv6atp_pkg::ChLowerA + HexLetterVal);
      else begin
        failed = 1'b1;
        return;
      end
      hex_acc = (hex_acc << 4) + hv;
      if (is_digit) dec_acc = 16'(dec_acc * DecimalBase + hv);
      else if (dotted) failed = 1'b1;
    endfunction

    function void note_char(ipv6atp_pkg::in_item_t item);
      ipv6atp_pkg::out_item_t r;
      logic [15:0] port;
      int          n;
      int          z;
      int          span;
      port = '0;
      if (!failed && !stopped) begin
        live_chars++;
        parse_char(item.ch);
      end
      if (!item.last) return;
      if (!failed) begin
        if (want_port) begin
          port = dec_acc;
        end else if (n_groups >= ipv6atp_pkg::NumGroups) begin
          failed = 1'b1;
        end else if (dotted) begin
          groups[n_groups] = (groups[n_groups] << 8) + dec_acc;
          n_groups++;
        end else begin
          groups[n_groups] = hex_acc;
          n_groups++;
        end
      end
      r = '0;
      if (!failed) begin
        n    = (n_groups > ipv6atp_pkg::NumGroups) ? ipv6atp_pkg::NumGroups : n_groups;
        z    = (zero_pos > n) ? n : zero_pos;
        span = n - z;
        for (int i = 0; i < ipv6atp_pkg::NumGroups - z; i++) begin
          groups[7 - i] = (i < span) ? groups[(n - 1 - i) & 7] : 16'h0000;
        end
        r.word0       = groups[0];
        r.word1       = groups[1];
        r.word2       = groups[2];
        r.word3       = groups[3];
        r.word4       = groups[4];
        r.word5       = groups[5];
        r.word6       = groups[6];
        r.word7       = groups[7];
        r.port_number = port;
        r.ok          = 1'b1;
      end
      expected_q.push_back(r);
      clear();
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void check_address(ipv6atp_pkg::out_item_t got);
      ipv6atp_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      results++;
      compare_field("word0", want.word0, got.word0);
      compare_field("word1", want.word1, got.word1);
      compare_field("word2", want.word2, got.word2);
      compare_field("word3", want.word3, got.word3);
      compare_field("word4", want.word4, got.word4);
      compare_field("word5", want.word5, got.word5);
      compare_field("word6", want.word6, got.word6);
      compare_field("word7", want.word7, got.word7);
      compare_field("port_number", want.port_number, got.port_number);
      compare_field("ok", {15'd0, want.ok}, {15'd0, got.ok});
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  ipv6atp_pkg::in_item_t  in_data_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  ipv6atp_pkg::out_item_t out_data_o;

  address_scoreboard sb = new();
  logic [7:0]        text_q[$];
  bit                in_quiet;
  int                idle_cycles;

  ipv6_address_text_parser uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (in_quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_char(logic [7:0] c, logic is_last);
    ipv6atp_pkg::in_item_t item;
    int       gap;
    item.ch   = c;
    item.last = is_last;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_char(item);
  endtask

  task automatic send_text_q();
    for (int i = 0; i < text_q.size(); i++) begin
      send_char(text_q[i], i == text_q.size() - 1);
    end
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  task automatic send_text(string s);
    text_q.delete();
    add_text(s);
    send_text_q();
  endtask

  function automatic void add_hex(int digits);
    int v;
    for (int k = 0; k < digits; k++) begin
      v = $urandom_range(0, 15);
      if (v < HexLetterVal) text_q.push_back(8'(ipv6atp_pkg::ChDigit0 + v));
      else text_q.push_back(8'(($urandom_range(0, 1) ? ipv6atp_pkg::ChUpperA
                                                     : ipv6atp_pkg::ChLowerA)
                               + v - HexLetterVal));
    end
  endfunction

  function automatic int pick_byte_value();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(256, 99999) : $urandom_range(0, 255);
  endfunction

  function automatic void build_address();
    int n_grp;
    int zp;
    int r;
    bit bracket;
    bit zeros;
    bit closed;
    text_q.delete();
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(1, 255)));
      return;
    end
    bracket = ($urandom_range(0, 2) == 0);
    if (bracket) text_q.push_back(ipv6atp_pkg::ChOpenBracket);
    n_grp = ($urandom_range(0, 20) == 0) ? 9 : $urandom_range(1, 8);
    zeros = $urandom_range(0, 1);
    zp    = $urandom_range(0, n_grp);
    for (int i = 0; i < n_grp; i++) begin
      if (i > 0) text_q.push_back(ipv6atp_pkg::ChColon);
      if (zeros && i == zp) begin
        text_q.push_back(ipv6atp_pkg::ChColon);
        if (i == 0) text_q.push_back(ipv6atp_pkg::ChColon);
      end
      r = $urandom_range(0, 99);
      if (i == n_grp - 1 && r < 15) begin
        add_text($sformatf("%0d.%0d", pick_byte_value(), pick_byte_value()));
        if ($urandom_range(0, 5) == 0) add_text($sformatf(".%0d", pick_byte_value()));
      end else if (r < 20) begin
        add_hex($urandom_range(5, 6));
      end else if (r >= 23) begin
        add_hex($urandom_range(1, 4));
      end
    end
    if (zeros && zp == n_grp) begin
      text_q.push_back(ipv6atp_pkg::ChColon);
      text_q.push_back(ipv6atp_pkg::ChColon);
    end
    closed = bracket && ($urandom_range(0, 9) != 0);
    if (closed) text_q.push_back(ipv6atp_pkg::ChCloseBracket);
    if ($urandom_range(0, 2) == 0) begin
      text_q.push_back(closed ? ipv6atp_pkg::ChColon : ipv6atp_pkg::ChPipe);
      add_text($sformatf("%0d", ($urandom_range(0, 9) == 0) ? $urandom_range(65536, 999999)
                                                             : $urandom_range(0, 65535)));
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 2))
          0: text_q.push_back(ipv6atp_pkg::ChColon);
          1: text_q.push_back(ipv6atp_pkg::ChDot);
          default: text_q.push_back(ipv6atp_pkg::ChPipe);
        endcase
        repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(1, 255)));
      end
    end
    if (text_q.size() > 0 && $urandom_range(0, 7) == 0) begin
      text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(1, 255));
    end
  endfunction

  initial begin
    int strings;
    int random_start;
    strings    = 0;
    in_quiet   = 1'b0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("::");
    send_text("1::2::3");
    send_text("[::1]:80");
    send_text("fe80|99999");
    send_text("12345");
    send_text("AbCdEf:09");
    send_text("1.2.3");
    send_text("1.a");
    send_text("1:2:3:4:5:6:7:8");
    send_text("1:2:3:4:5:6:7:8:");
    send_text("1:2:3:4:5:6:7:8:1.2");
    send_text("[1]:5:g");
    send_text("g");
    send_char(8'h01, 1'b1);
    send_char(8'hFF, 1'b1);
    strings = 15;

    random_start = sb.live_chars;
    while (sb.live_chars - random_start < RandomChars) begin
      if ($urandom_range(0, 3) == 0) in_quiet = ~in_quiet;
      build_address();
      send_text_q();
      strings++;
    end
    in_valid_i <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Parsed %0d address strings (%0d live characters), %0d results checked.",
             strings, sb.live_chars, sb.results);
    $display("Mismatches: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    int  run;
    int  r;
    bit  stall_now;
    run       = 0;
    stall_now = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) sb.check_address(out_data_o);
      if (run == 0) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          stall_now = 1'b0;
          run = $urandom_range(1, 6);
        end else if (r < 60) begin
          stall_now = 1'b0;
          run = $urandom_range(20, 80);
        end else if (r < 92) begin
          stall_now = 1'b1;
          run = $urandom_range(1, 3);
        end else begin
          stall_now = 1'b1;
          run = $urandom_range(8, 40);
        end
      end
      run--;
      out_stall_i <= stall_now;
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule
